@@ hw/rtl/adcm_pkg.sv @@
// ---------------------------------------------------------------------------
// ADC group scan monitor package
// Shared constants, request and lane operation codes, record types and
// the group selection helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package adcm_pkg;

  // Channel organization.
  localparam int NUM_CHANNELS = 16;
  localparam int RESULT_SHIFT = 6;
  localparam int NUM_GROUPS   = NUM_CHANNELS / 4;
  localparam int LANES        = 4;
  localparam int SLOTS        = 4;

  // Limits on stored values.
  localparam logic [10:0] LIMIT_MAX  = 11'd1024;
  localparam logic [9:0]  SAMPLE_MAX = 10'd1023;

  // Last step of the range-check sweep.
  localparam logic [1:0] STEP_LAST = 2'(NUM_GROUPS - 1);

  // Request codes.
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_CONV  = 3'd1;
  localparam logic [2:0] REQ_RANGE = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // Lane operation codes.
  localparam logic [2:0] LOP_IDLE  = 3'd0;
  localparam logic [2:0] LOP_CHECK = 3'd1;
  localparam logic [2:0] LOP_CONV  = 3'd2;
  localparam logic [2:0] LOP_RANGE = 3'd3;
  localparam logic [2:0] LOP_CLEAR = 3'd4;

  // Multiplexer codes of the four groups.
  localparam logic [3:0] MUX_CODES [4] = '{4'd3, 4'd7, 4'd11, 4'd15};

  // Command from the sequencer to one lane.
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] addr;
  } lane_cmd_t;

  // Records of one channel as read out of a lane.
  typedef struct packed {
    logic [10:0] value;
    logic [10:0] min;
    logic [9:0]  max;
    logic [15:0] count;
    logic [31:0] oor;
    logic [10:0] lo;
    logic [10:0] hi;
  } rec_t;

  // Outcome of a group search.
  typedef struct packed {
    logic       found;
    logic [1:0] idx;
  } grp_sel_t;

  // First enabled group at or after 'from'.
  function automatic grp_sel_t first_group(input logic [15:0] mask, input logic [2:0] from);
    grp_sel_t res;
    res = '0;
    for (int g = 3; g >= 0; g--) begin
      if (g >= int'(from) && g < NUM_GROUPS && mask[4*g +: 4] != 4'd0) begin
        res.found = 1'b1;
        res.idx   = 2'(g);
      end
    end
    return res;
  endfunction

  // Saturate a limit at LIMIT_MAX.
  function automatic logic [10:0] sat_limit(input logic [10:0] v);
    return (v > LIMIT_MAX) ? LIMIT_MAX : v;
  endfunction

endpackage

@@ hw/rtl/adcm_lane.sv @@
// ---------------------------------------------------------------------------
// ADC monitor lane
// Holds the records of one channel position across the four groups and
// performs range checks, conversion updates, limit writes and clears.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adcm_lane import adcm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lane_cmd_t   cmd,
  input  logic [15:0] raw,
  input  logic [10:0] lim_low,
  input  logic [10:0] lim_high,
  output rec_t        rec
);

  logic [10:0] last_value [SLOTS];
  logic [10:0] min_value  [SLOTS];
  logic [9:0]  max_value  [SLOTS];
  logic [15:0] sample_count [SLOTS];
  logic [31:0] oor_count  [SLOTS];
  logic [10:0] limit_low  [SLOTS];
  logic [10:0] limit_high [SLOTS];

  logic [15:0] shifted;
  logic [9:0]  samp;
  logic        out_of_range;
  logic [10:0] raised;
  logic [10:0] clamped;

  // Read the addressed slot.
  always_comb begin
    rec.value = last_value[cmd.addr];
    rec.min   = min_value[cmd.addr];
    rec.max   = max_value[cmd.addr];
    rec.count = sample_count[cmd.addr];
    rec.oor   = oor_count[cmd.addr];
    rec.lo    = limit_low[cmd.addr];
    rec.hi    = limit_high[cmd.addr];
  end

  // Conversion result, range check and limit clamp of the addressed slot.
  always_comb begin
    shifted      = raw >> RESULT_SHIFT;
    samp         = (shifted > 16'(SAMPLE_MAX)) ? SAMPLE_MAX : shifted[9:0];
    out_of_range = (rec.value < rec.lo) || (rec.value > rec.hi);
    raised       = (rec.value < lim_low) ? lim_low : rec.value;
    clamped      = (raised > lim_high) ? lim_high : raised;
  end

  // Record update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        last_value[i]   <= '0;
        min_value[i]    <= LIMIT_MAX;
        max_value[i]    <= '0;
        sample_count[i] <= '0;
        oor_count[i]    <= '0;
        limit_low[i]    <= '0;
        limit_high[i]   <= LIMIT_MAX;
      end
    end else begin
      case (cmd.op)
        LOP_CHECK: begin
          if (out_of_range) begin
            oor_count[cmd.addr] <= oor_count[cmd.addr] + 32'd1;
          end
        end
        LOP_CONV: begin
          sample_count[cmd.addr] <= sample_count[cmd.addr] + 16'd1;
          last_value[cmd.addr]   <= {1'b0, samp};
          if (samp > rec.max) begin
            max_value[cmd.addr] <= samp;
          end
          if ({1'b0, samp} < rec.min) begin
            min_value[cmd.addr] <= {1'b0, samp};
          end
        end
        LOP_RANGE: begin
          limit_low[cmd.addr]  <= lim_low;
          limit_high[cmd.addr] <= lim_high;
          last_value[cmd.addr] <= clamped;
        end
        LOP_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) begin
            min_value[i]    <= LIMIT_MAX;
            max_value[i]    <= '0;
            sample_count[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/adcm_merge.sv @@
// ---------------------------------------------------------------------------
// ADC monitor result merge
// Picks the addressed lane's records, adds the scan status and holds the
// result for its one-cycle strobe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adcm_merge import adcm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        capture,
  input  logic        rd_en,
  input  logic [1:0]  lane_sel,
  input  rec_t        lane_rec [LANES],
  input  logic        group_active,
  input  logic [1:0]  group_index,
  output logic        done,
  output logic        scan_active,
  output logic [1:0]  current_group,
  output logic [3:0]  mux_select,
  output logic [10:0] chan_value,
  output logic [10:0] chan_min,
  output logic [9:0]  chan_max,
  output logic [15:0] chan_count,
  output logic [31:0] chan_oor_count,
  output logic [10:0] chan_range_low,
  output logic [10:0] chan_range_high
);

  rec_t sel_rec;

  // Addressed lane, or zeros when the request is not a valid read.
  assign sel_rec = rd_en ? lane_rec[lane_sel] : '0;

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= capture;
    end
  end

  // Result fields.
  always_ff @(posedge clk) begin
    if (capture) begin
      scan_active     <= group_active;
      current_group   <= group_active ? group_index : 2'd0;
      mux_select      <= group_active ? MUX_CODES[group_index] : 4'd0;
      chan_value      <= sel_rec.value;
      chan_min        <= sel_rec.min;
      chan_max        <= sel_rec.max;
      chan_count      <= sel_rec.count;
      chan_oor_count  <= sel_rec.oor;
      chan_range_low  <= sel_rec.lo;
      chan_range_high <= sel_rec.hi;
    end
  end

endmodule

@@ hw/rtl/adc_group_scan_monitor.sv @@
// ---------------------------------------------------------------------------
// ADC group scan monitor
// Sixteen-channel monitor scanning four groups of four channels, with
// per-channel limits, min, max, sample and out-of-range counters.
// ---------------------------------------------------------------------------
// Usage: raise start with a request while busy is low; busy stays high
// until the result is shown, and done is high for a single cycle once
// the result ports hold it. The receiver cannot stall, so capture the
// result when done is high. A start-scan request range-checks every
// group slot before its response, because the four lanes range-check one
// group slot per cycle; every other request has a single execute step. A
// new request can be accepted in the done cycle. The enable mask is
// written through cfg_valid/cfg_data, which is always ready; write it only
// while the block is idle.
`timescale 1ns / 1ps

module adc_group_scan_monitor import adcm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic        conversion_flag,
  input  logic [15:0] sample_a,
  input  logic [15:0] sample_b,
  input  logic [15:0] sample_c,
  input  logic [15:0] sample_d,
  input  logic [3:0]  channel,
  input  logic [10:0] range_low,
  input  logic [10:0] range_high,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic        scan_active,
  output logic [1:0]  current_group,
  output logic [3:0]  mux_select,
  output logic [10:0] chan_value,
  output logic [10:0] chan_min,
  output logic [9:0]  chan_max,
  output logic [15:0] chan_count,
  output logic [31:0] chan_oor_count,
  output logic [10:0] chan_range_low,
  output logic [10:0] chan_range_high
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]  state;
  logic [1:0]  step;
  logic [2:0]  req;
  logic        flag;
  logic [3:0]  ch;
  logic [15:0] sample_q [LANES];
  logic [10:0] lim_low;
  logic [10:0] lim_high;
  logic [15:0] group_enable;
  logic        group_active;
  logic [1:0]  group_index;

  logic        accept;
  logic        ch_ok;
  logic        exec_last;
  grp_sel_t    sel_start;
  grp_sel_t    sel_next;
  lane_cmd_t   lane_cmd [LANES];
  rec_t        lane_rec [LANES];

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign ch_ok     = ({1'b0, ch} < 5'(NUM_CHANNELS));
  assign exec_last = (req != REQ_START) || (step == STEP_LAST);
  assign sel_start = first_group(group_enable, 3'd0);
  assign sel_next  = first_group(group_enable, {1'b0, group_index} + 3'd1);

  // Enable mask register.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_enable <= 16'hffff;
    end else if (cfg_valid && cfg_ready) begin
      group_enable <= cfg_data;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      req         <= req_type;
      flag        <= conversion_flag;
      ch          <= channel;
      sample_q[0] <= sample_a;
      sample_q[1] <= sample_b;
      sample_q[2] <= sample_c;
      sample_q[3] <= sample_d;
      lim_low     <= sat_limit(range_low);
      lim_high    <= sat_limit(range_high);
    end
  end

  // Sequencer and group selection.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      group_active <= 1'b0;
      group_index  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          step <= step + 2'd1;
          if (exec_last) begin
            state <= ST_RESP;
            if (req == REQ_START) begin
              group_active <= sel_start.found;
              group_index  <= sel_start.idx;
            end else if (req == REQ_CONV && group_active) begin
              group_active <= sel_next.found;
              group_index  <= sel_next.idx;
            end
          end
        end
        ST_RESP: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Lane commands.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_cmd[k].op   = LOP_IDLE;
      lane_cmd[k].addr = ch[3:2];
      if (state == ST_EXEC) begin
        case (req)
          REQ_START: begin
            lane_cmd[k].op   = LOP_CHECK;
            lane_cmd[k].addr = step;
          end
          REQ_CONV: begin
            lane_cmd[k].addr = group_index;
            if (group_active && flag) begin
              lane_cmd[k].op = LOP_CONV;
            end
          end
          REQ_RANGE: begin
            if (ch_ok && ch[1:0] == 2'(k)) begin
              lane_cmd[k].op = LOP_RANGE;
            end
          end
          REQ_CLEAR: begin
            lane_cmd[k].op = LOP_CLEAR;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Channel lanes.
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    adcm_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .cmd      (lane_cmd[k]),
      .raw      (sample_q[k]),
      .lim_low  (lim_low),
      .lim_high (lim_high),
      .rec      (lane_rec[k])
    );
  end

  // Result merge.
  adcm_merge u_merge (
    .clk             (clk),
    .rst             (rst),
    .capture         (state == ST_RESP),
    .rd_en           ((req == REQ_READ) && ch_ok),
    .lane_sel        (ch[1:0]),
    .lane_rec        (lane_rec),
    .group_active    (group_active),
    .group_index     (group_index),
    .done            (done),
    .scan_active     (scan_active),
    .current_group   (current_group),
    .mux_select      (mux_select),
    .chan_value      (chan_value),
    .chan_min        (chan_min),
    .chan_max        (chan_max),
    .chan_count      (chan_count),
    .chan_oor_count  (chan_oor_count),
    .chan_range_low  (chan_range_low),
    .chan_range_high (chan_range_high)
  );

  // The result appears once the sequencer has gone back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // Results never come in adjacent cycles.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // An accepted request always starts execution.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted request did not start");

  // Single-step requests go straight to the response cycle.
  a_short_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && req != REQ_START) |=> state == ST_RESP)
    else $error("single-step request overran");

  // An idle report carries no group.
  a_idle_status: assert property (@(posedge clk) disable iff (rst)
    (done && !scan_active) |-> (current_group == 2'd0 && mux_select == 4'd0))
    else $error("idle result carries a group");

endmodule

@@ dv/adc_group_scan_monitor_test.sv @@
// ---------------------------------------------------------------------------
// ADC group scan monitor testbench
// Feeds directed and random request streams through the command port,
// predicts every result with an in-bench model of the channel records and
// the group sequencer, and compares each done strobe field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_group_scan_monitor_test;
  import adcm_pkg::*;

  // Request codes the block treats as no-ops.
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
  localparam int         PRINT_LIMIT     = 40;

  typedef struct packed {
    logic [2:0]       req;
    logic             conv_flag;
    logic [3:0][15:0] sample;
    logic [3:0]       chan;
    logic [10:0]      lo;
    logic [10:0]      hi;
  } scan_req_t;

  typedef struct packed {
    logic        active;
    logic [1:0]  grp;
    logic [3:0]  mux;
    logic [10:0] value;
    logic [10:0] min;
    logic [9:0]  max;
    logic [15:0] count;
    logic [31:0] oor;
    logic [10:0] rlo;
    logic [10:0] rhi;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  req_type = '0;
  logic        conversion_flag = 1'b0;
  logic [15:0] sample_a = '0;
  logic [15:0] sample_b = '0;
  logic [15:0] sample_c = '0;
  logic [15:0] sample_d = '0;
  logic [3:0]  channel = '0;
  logic [10:0] range_low = '0;
  logic [10:0] range_high = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic        scan_active;
  logic [1:0]  current_group;
  logic [3:0]  mux_select;
  logic [10:0] chan_value;
  logic [10:0] chan_min;
  logic [9:0]  chan_max;
  logic [15:0] chan_count;
  logic [31:0] chan_oor_count;
  logic [10:0] chan_range_low;
  logic [10:0] chan_range_high;

  // Predicted state of the monitor.
  logic [15:0] group_mask;
  logic        scan_on;
  logic [1:0]  scan_group;
  logic [10:0] seen_value [16];
  logic [10:0] seen_min   [16];
  logic [9:0]  seen_max   [16];
  logic [15:0] seen_count [16];
  logic [31:0] oor_tally  [16];
  logic [10:0] lim_lo     [16];
  logic [10:0] lim_hi     [16];

  scan_req_t    req_backlog[$];
  scan_result_t scan_results_due[$];
  scan_req_t    cur_req;

  int idle_pct = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int mask_writes = 0;
  int reqs_by_kind [8];

  adc_group_scan_monitor DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .conversion_flag (conversion_flag),
    .sample_a        (sample_a),
    .sample_b        (sample_b),
    .sample_c        (sample_c),
    .sample_d        (sample_d),
    .channel         (channel),
    .range_low       (range_low),
    .range_high      (range_high),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .done            (done),
    .scan_active     (scan_active),
    .current_group   (current_group),
    .mux_select      (mux_select),
    .chan_value      (chan_value),
    .chan_min        (chan_min),
    .chan_max        (chan_max),
    .chan_count      (chan_count),
    .chan_oor_count  (chan_oor_count),
    .chan_range_low  (chan_range_low),
    .chan_range_high (chan_range_high)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Select the first enabled group at or after 'from', or fall idle.
  function automatic void select_group(input int from);
    scan_on    = 1'b0;
    scan_group = '0;
    for (int g = from; g < NUM_GROUPS; g++) begin
      if (group_mask[4*g +: 4] != 4'd0) begin
        scan_on    = 1'b1;
        scan_group = 2'(g);
        return;
      end
    end
  endfunction

  // Apply one request to the predicted state and return the result it shows.
  function automatic scan_result_t predict_scan_result(input scan_req_t it);
    scan_result_t r;
    logic [15:0]  conv;
    logic [9:0]   s;
    logic [10:0]  lo;
    logic [10:0]  hi;
    int           c;
    r = '0;
    case (it.req)
      REQ_START: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (seen_value[i] < lim_lo[i] || seen_value[i] > lim_hi[i]) oor_tally[i]++;
        end
        select_group(0);
      end
      REQ_CONV: begin
        // A conversion while idle changes nothing.
        if (scan_on) begin
          if (it.conv_flag) begin
            for (int k = 0; k < 4; k++) begin
              c    = int'(scan_group) * 4 + k;
              conv = it.sample[k] >> RESULT_SHIFT;
              s    = (conv > SAMPLE_MAX) ? SAMPLE_MAX : conv[9:0];
              seen_count[c]++;
              seen_value[c] = {1'b0, s};
              if (s > seen_max[c]) seen_max[c] = s;
              if ({1'b0, s} < seen_min[c]) seen_min[c] = {1'b0, s};
            end
          end
          select_group(int'(scan_group) + 1);
        end
      end
      REQ_RANGE: begin
        // Limits saturate; crossed limits leave the value at the high limit.
        c  = int'(it.chan);
        lo = (it.lo > LIMIT_MAX) ? LIMIT_MAX : it.lo;
        hi = (it.hi > LIMIT_MAX) ? LIMIT_MAX : it.hi;
        lim_lo[c] = lo;
        lim_hi[c] = hi;
        if (seen_value[c] < lo) seen_value[c] = lo;
        if (seen_value[c] > hi) seen_value[c] = hi;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < 16; i++) begin
          seen_min[i]   = LIMIT_MAX;
          seen_max[i]   = '0;
          seen_count[i] = '0;
        end
      end
      REQ_READ: begin
        c       = int'(it.chan);
        r.value = seen_value[c];
        r.min   = seen_min[c];
        r.max   = seen_max[c];
        r.count = seen_count[c];
        r.oor   = oor_tally[c];
        r.rlo   = lim_lo[c];
        r.rhi   = lim_hi[c];
      end
      default: ;
    endcase
    r.active = scan_on;
    r.grp    = scan_on ? scan_group : 2'd0;
    r.mux    = scan_on ? MUX_CODES[scan_group] : 4'd0;
    return r;
  endfunction

  function automatic scan_req_t compose_req(input logic [2:0] op, input logic [3:0] ch = 4'd0,
                                            input logic [10:0] lo = 11'd0,
                                            input logic [10:0] hi = 11'd0,
                                            input logic flag = 1'b1,
                                            input logic [15:0] s0 = 16'd0,
                                            input logic [15:0] s1 = 16'd0,
                                            input logic [15:0] s2 = 16'd0,
                                            input logic [15:0] s3 = 16'd0);
    scan_req_t r;
    r.req       = op;
    r.conv_flag = flag;
    r.sample    = {s3, s2, s1, s0};
    r.chan      = ch;
    r.lo        = lo;
    r.hi        = hi;
    return r;
  endfunction

  // Random content for one request; every field is filled whatever the code.
  function automatic scan_req_t random_req(input logic [2:0] op);
    scan_req_t r;
    r.req       = op;
    r.conv_flag = ($urandom_range(0, 9) != 0);
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 19))
        0:       r.sample[k] = 16'h0000;
        1:       r.sample[k] = 16'hFFFF;
        default: r.sample[k] = 16'($urandom_range(0, 65535));
      endcase
    end
    r.chan = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 4) == 0) begin
      r.lo = 11'($urandom_range(0, 2047));
      r.hi = 11'($urandom_range(0, 2047));
    end else begin
      r.lo = 11'($urandom_range(0, 800));
      r.hi = r.lo + 11'($urandom_range(0, 400));
    end
    return r;
  endfunction

  // Mostly scan sequences (start, then conversions with reads mixed in),
  // the rest single requests of every kind but start.
  task automatic queue_random_phase(input int n);
    int queued;
    int pick;
    int convs;
    queued = 0;
    while (queued < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        req_backlog.push_back(random_req(REQ_START));
        queued++;
        convs = $urandom_range(1, NUM_GROUPS + 1);
        for (int k = 0; k < convs; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            req_backlog.push_back(random_req(REQ_READ));
            queued++;
          end
          req_backlog.push_back(random_req(REQ_CONV));
          queued++;
        end
      end else begin
        if (pick < 77)      req_backlog.push_back(random_req(REQ_RANGE));
        else if (pick < 90) req_backlog.push_back(random_req(REQ_READ));
        else if (pick < 93) req_backlog.push_back(random_req(REQ_CLEAR));
        else if (pick < 96)
          req_backlog.push_back(random_req(3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST))));
        else                req_backlog.push_back(random_req(REQ_CONV));
        queued++;
      end
    end
  endtask

  // Hold off until every queued request is through and every result is in.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (req_backlog.size() != 0 || start || scan_results_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Write the group mask while the block is idle.
  task automatic write_group_mask(input logic [15:0] m);
    wait_for_drain();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    group_mask = m;
    mask_writes++;
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("MISMATCH at %0t ns: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Driver: present requests from the backlog, predicting each one as its
  // transfer completes.
  always @(posedge clk) begin : drive_requests
    logic fire;
    fire = start;
    if (!rst) begin
      if (start && !busy) begin
        scan_results_due.push_back(predict_scan_result(cur_req));
        reqs_by_kind[cur_req.req]++;
        fire = 1'b0;
      end
      if (!fire && req_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        cur_req         = req_backlog.pop_front();
        req_type        <= cur_req.req;
        conversion_flag <= cur_req.conv_flag;
        sample_a        <= cur_req.sample[0];
        sample_b        <= cur_req.sample[1];
        sample_c        <= cur_req.sample[2];
        sample_d        <= cur_req.sample[3];
        channel         <= cur_req.chan;
        range_low       <= cur_req.lo;
        range_high      <= cur_req.hi;
        fire = 1'b1;
      end
      start <= fire;
    end
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk) begin : check_results
    scan_result_t e;
    if (!rst && done) begin
      if (scan_results_due.size() == 0) begin
        report_mismatch("result with no request pending", 1, 0);
      end else begin
        e = scan_results_due.pop_front();
        results_checked++;
        if (scan_active !== e.active)    report_mismatch("scan_active", scan_active, e.active);
        if (current_group !== e.grp)     report_mismatch("current_group", current_group, e.grp);
        if (mux_select !== e.mux)        report_mismatch("mux_select", mux_select, e.mux);
        if (chan_value !== e.value)      report_mismatch("chan_value", chan_value, e.value);
        if (chan_min !== e.min)          report_mismatch("chan_min", chan_min, e.min);
        if (chan_max !== e.max)          report_mismatch("chan_max", chan_max, e.max);
        if (chan_count !== e.count)      report_mismatch("chan_count", chan_count, e.count);
        if (chan_oor_count !== e.oor)    report_mismatch("chan_oor_count", chan_oor_count, e.oor);
        if (chan_range_low !== e.rlo)    report_mismatch("chan_range_low", chan_range_low, e.rlo);
        if (chan_range_high !== e.rhi)   report_mismatch("chan_range_high", chan_range_high, e.rhi);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [15:0] phase_masks [5];
    phase_masks = '{16'hFFFF, 16'h0001, 16'h8000, 16'h0F0F, 16'h2480};

    // State after reset.
    group_mask = 16'hFFFF;
    scan_on    = 1'b0;
    scan_group = '0;
    for (int i = 0; i < 16; i++) begin
      seen_value[i] = '0;
      seen_min[i]   = LIMIT_MAX;
      seen_max[i]   = '0;
      seen_count[i] = '0;
      oor_tally[i]  = '0;
      lim_lo[i]     = '0;
      lim_hi[i]     = LIMIT_MAX;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset records, a conversion while idle, a restart while active,
    // saturated and crossed limits, the spare codes and a clear.
    req_backlog.push_back(compose_req(REQ_READ, 4'd0));
    req_backlog.push_back(compose_req(REQ_READ, 4'd15));
    req_backlog.push_back(compose_req(REQ_CONV, 4'd0, 11'd0, 11'd0, 1'b1,
                                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    req_backlog.push_back(compose_req(REQ_START));
    req_backlog.push_back(compose_req(REQ_CONV, 4'd0, 11'd0, 11'd0, 1'b1,
                                      16'hFFFF, 16'h0000, 16'h8000, 16'h003F));
    req_backlog.push_back(compose_req(REQ_CONV, 4'd0, 11'd0, 11'd0, 1'b0));
    req_backlog.push_back(compose_req(REQ_START));
    req_backlog.push_back(compose_req(REQ_CONV, 4'd0, 11'd0, 11'd0, 1'b1,
                                      16'h0040, 16'hFFC0, 16'h1234, 16'hFFFF));
    req_backlog.push_back(compose_req(REQ_RANGE, 4'd1, 11'd2047, 11'd2047));
    req_backlog.push_back(compose_req(REQ_RANGE, 4'd2, 11'd600, 11'd100));
    req_backlog.push_back(compose_req(REQ_RANGE, 4'd15, 11'd1024, 11'd0));
    req_backlog.push_back(compose_req(REQ_READ, 4'd1));
    req_backlog.push_back(compose_req(REQ_READ, 4'd2));
    req_backlog.push_back(compose_req(REQ_START));
    req_backlog.push_back(compose_req(REQ_READ, 4'd2));
    req_backlog.push_back(compose_req(REQ_SPARE_FIRST, 4'd2));
    req_backlog.push_back(compose_req(3'(REQ_SPARE_FIRST + 3'd1), 4'd3));
    req_backlog.push_back(compose_req(REQ_SPARE_LAST, 4'd15));
    req_backlog.push_back(compose_req(REQ_CLEAR));
    req_backlog.push_back(compose_req(REQ_READ, 4'd0));

    // No group enabled: a scan falls idle at once.
    write_group_mask(16'h0000);
    req_backlog.push_back(compose_req(REQ_START));
    req_backlog.push_back(compose_req(REQ_CONV, 4'd0, 11'd0, 11'd0, 1'b1,
                                      16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    req_backlog.push_back(compose_req(REQ_READ, 4'd3));

    // Two sparse groups, then a conversion after the scan has ended.
    write_group_mask(16'h8010);
    req_backlog.push_back(compose_req(REQ_START));
    req_backlog.push_back(compose_req(REQ_CONV, 4'd0, 11'd0, 11'd0, 1'b1,
                                      16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    req_backlog.push_back(compose_req(REQ_CONV, 4'd0, 11'd0, 11'd0, 1'b1,
                                      16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    req_backlog.push_back(compose_req(REQ_CONV, 4'd0, 11'd0, 11'd0, 1'b1,
                                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    // Random phases: sender gaps at 30 percent, then 88, then none.
    for (int p = 0; p < 11; p++) begin
      write_group_mask(p < 5 ? phase_masks[p] : 16'($urandom_range(1, 65535)));
      idle_pct = (p < 4) ? 30 : ((p < 8) ? 88 : 0);
      queue_random_phase(150);
    end

    wait_for_drain();
    $display("Covered %0d scan starts, %0d conversions, %0d range writes, %0d clears,",
             reqs_by_kind[REQ_START], reqs_by_kind[REQ_CONV], reqs_by_kind[REQ_RANGE],
             reqs_by_kind[REQ_CLEAR]);
    $display("%0d reads and %0d spare codes; %0d results compared over %0d mask settings.",
             reqs_by_kind[REQ_READ],
             reqs_by_kind[5] + reqs_by_kind[6] + reqs_by_kind[7],
             results_checked, mask_writes);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(10_000_000);
    $display("Timeout: %0d results still pending", scan_results_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
